@@ design/dcbrf_pkg.sv @@
// Package for the dual-channel byte ring FIFO: item structs, mode codes,
// default sizes and the result-building helper. No dependencies.
`default_nettype none

package dcbrf_pkg;

    localparam int DEPTH_DEFAULT    = 64;
    localparam int CHANNELS_DEFAULT = 2;
    localparam int COUNT_W          = 7;
    localparam int BYTE_W           = 8;
    localparam int MODE_W           = 3;

    localparam logic [MODE_W-1:0] MODE_PUSH      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RUN_READ  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RUN_WRITE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_STATUS    = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               channel;
        logic [BYTE_W-1:0]  data_byte;
        logic [COUNT_W-1:0] run_length;
        logic               run_first;
    } in_item_t;

    typedef struct packed {
        logic               ok;
        logic [BYTE_W-1:0]  read_byte;
        logic [COUNT_W-1:0] used_count;
        logic [COUNT_W-1:0] free_count;
        logic               is_empty;
        logic               is_full;
        logic               last;
    } out_item_t;

    // Builds a result item from the fill count that stands after the step.
    function automatic out_item_t make_result(
        input logic               ok,
        input logic [BYTE_W-1:0]  rd_byte,
        input logic [COUNT_W-1:0] used,
        input logic               last,
        input logic [COUNT_W-1:0] depth
    );
        out_item_t r;
        r.ok         = ok;
        r.read_byte  = rd_byte;
        r.used_count = used;
        r.free_count = depth - used;
        r.is_empty   = (used == '0);
        r.is_full    = (used >= depth);
        r.last       = last;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/dcbrf_store.sv @@
// Byte store shared by all channels: one write port and one registered read
// port. Depends on dcbrf_pkg for the byte width.
`default_nettype none

module dcbrf_store #(
    parameter int ADDR_W = 7
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic [dcbrf_pkg::BYTE_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    output logic      [dcbrf_pkg::BYTE_W-1:0] rd_data
);
    import dcbrf_pkg::*;

    localparam int MEM_DEPTH = 1 << ADDR_W;

    logic [BYTE_W-1:0] mem [MEM_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/dual_channel_byte_ring_fifo.sv @@
// Top level of the dual-channel byte ring FIFO: handshakes, per-channel
// pointers and counts, and the sequencer. Depends on dcbrf_pkg, dcbrf_store.
`default_nettype none

// Each channel owns a ring of BUF_DEPTH bytes (a power of two) with head and
// tail pointers that wrap naturally and a fill count; all rings share one
// byte store with a single registered read port. The block works on one item
// at a time and is not ready while an item is in progress. A push, run write,
// status or rejected item is executed and its result registered; a pop or
// peek first reads its byte from the store, and the result register takes
// it in a wait state after execute. A run read of N bytes first reserves
// the bytes in the execute state and then produces each byte by issuing the
// store read, capturing the data into the result register and handing the
// item over, so the next byte is not read before the last one is taken. The
// registered store read and the single result register set this order. A
// new item is accepted in the cycle after the final result of the previous
// one has been taken. The byte store is not cleared at reset; only the
// control state, pointers, counts and run-write flags are. Every result
// reports the addressed channel's status after the whole step, so the
// bytes of a run read already show the count lowered by N.
module dual_channel_byte_ring_fifo #(
    parameter int BUF_DEPTH = dcbrf_pkg::DEPTH_DEFAULT,
    parameter int CHANNELS  = dcbrf_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire dcbrf_pkg::in_item_t  in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output dcbrf_pkg::out_item_t      out_item
);
    import dcbrf_pkg::*;

    localparam int PTR_W  = $clog2(BUF_DEPTH);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W = CH_W + PTR_W;
    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(BUF_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_EXEC     = 5'b00010,
        ST_RD_ISSUE = 5'b00100,
        ST_RD_WAIT  = 5'b01000,
        ST_OUT      = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    in_item_t           req_reg, req_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [COUNT_W-1:0] rd_left_reg, rd_left_next;
    out_item_t          out_reg, out_next;

    logic [PTR_W-1:0]   head_reg [CHANNELS];
    logic [PTR_W-1:0]   head_next [CHANNELS];
    logic [PTR_W-1:0]   tail_reg [CHANNELS];
    logic [PTR_W-1:0]   tail_next [CHANNELS];
    logic [COUNT_W-1:0] fill_reg [CHANNELS];
    logic [COUNT_W-1:0] fill_next [CHANNELS];
    logic [COUNT_W-1:0] wr_left_reg [CHANNELS];
    logic [COUNT_W-1:0] wr_left_next [CHANNELS];
    logic               wr_rej_reg [CHANNELS];
    logic               wr_rej_next [CHANNELS];

    // Current channel view.
    logic [PTR_W-1:0]   cur_head;
    logic [PTR_W-1:0]   cur_tail;
    logic [COUNT_W-1:0] cur_fill;
    logic [COUNT_W-1:0] cur_free;
    logic [COUNT_W-1:0] cur_wr_left;
    logic               cur_wr_rej;

    // The one fill adder/subtractor, shared by all modes that change a fill.
    logic [COUNT_W-1:0] alu_opnd;
    logic               alu_sub;
    logic [COUNT_W-1:0] alu_sum;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [BYTE_W-1:0]  mem_rdata;

    logic               ok;
    logic [COUNT_W-1:0] fill_after;
    logic [CH_W-1:0]    in_ch;

    assign cur_head    = head_reg[ch_reg];
    assign cur_tail    = tail_reg[ch_reg];
    assign cur_fill    = fill_reg[ch_reg];
    assign cur_free    = DEPTH_C - cur_fill;
    assign cur_wr_left = wr_left_reg[ch_reg];
    assign cur_wr_rej  = wr_rej_reg[ch_reg];
    assign alu_sum     = alu_sub ? (cur_fill - alu_opnd) : (cur_fill + alu_opnd);

    // With a single channel every item addresses channel zero.
    assign in_ch = (CHANNELS > 1) ? CH_W'(in_item.channel) : '0;

    assign mem_waddr = {ch_reg, cur_tail};
    assign mem_raddr = {ch_reg, cur_head};

    dcbrf_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (req_reg.data_byte),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        ch_next      = ch_reg;
        rd_left_next = rd_left_reg;
        out_next     = out_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        wr_left_next = wr_left_reg;
        wr_rej_next  = wr_rej_reg;
        alu_opnd     = COUNT_W'(1);
        alu_sub      = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        ok           = 1'b0;
        fill_after   = cur_fill;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_item;
                    ch_next    = in_ch;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_OUT;
                case (req_reg.mode)
                    MODE_PUSH:
                    begin
                        if (cur_fill < DEPTH_C)
                        begin
                            mem_we            = 1'b1;
                            tail_next[ch_reg] = cur_tail + 1'b1;
                            fill_after        = alu_sum;
                            ok                = 1'b1;
                        end
                    end

                    MODE_POP, MODE_PEEK:
                    begin
                        if (cur_fill != '0)
                        begin
                            mem_re       = 1'b1;
                            rd_left_next = '0;
                            state_next   = ST_RD_WAIT;
                            if (req_reg.mode == MODE_POP)
                            begin
                                alu_sub           = 1'b1;
                                head_next[ch_reg] = cur_head + 1'b1;
                                fill_after        = alu_sum;
                            end
                        end
                    end

                    MODE_RUN_READ:
                    begin
                        if (req_reg.run_length > cur_fill)
                        begin
                            ok = 1'b0;
                        end
                        else if (req_reg.run_length == '0)
                        begin
                            ok = 1'b1;
                        end
                        else
                        begin
                            // Reserve the whole run at once, then stream it.
                            alu_opnd     = req_reg.run_length;
                            alu_sub      = 1'b1;
                            fill_after   = alu_sum;
                            rd_left_next = req_reg.run_length;
                            state_next   = ST_RD_ISSUE;
                        end
                    end

                    MODE_RUN_WRITE:
                    begin
                        if (req_reg.run_first)
                        begin
                            if (req_reg.run_length > cur_free)
                            begin
                                wr_rej_next[ch_reg]  = 1'b1;
                                wr_left_next[ch_reg] = '0;
                            end
                            else
                            begin
                                wr_rej_next[ch_reg]  = 1'b0;
                                wr_left_next[ch_reg] = '0;
                                alu_opnd             = req_reg.run_length;
                                fill_after           = alu_sum;
                                ok                   = 1'b1;
                                if (req_reg.run_length != '0)
                                begin
                                    mem_we               = 1'b1;
                                    tail_next[ch_reg]    = cur_tail + 1'b1;
                                    wr_left_next[ch_reg] = req_reg.run_length - 1'b1;
                                end
                            end
                        end
                        else if (!cur_wr_rej && cur_wr_left != '0)
                        begin
                            // Space was reserved by the first item of the run.
                            mem_we               = 1'b1;
                            tail_next[ch_reg]    = cur_tail + 1'b1;
                            wr_left_next[ch_reg] = cur_wr_left - 1'b1;
                            ok                   = 1'b1;
                        end
                    end

                    MODE_STATUS:
                    begin
                        ok = 1'b1;
                    end

                    default:
                    begin
                        ok = 1'b0;
                    end
                endcase
                fill_next[ch_reg] = fill_after;
                out_next = make_result(ok, '0, fill_after, 1'b1, DEPTH_C);
            end

            ST_RD_ISSUE:
            begin
                mem_re            = 1'b1;
                head_next[ch_reg] = cur_head + 1'b1;
                rd_left_next      = rd_left_reg - 1'b1;
                state_next        = ST_RD_WAIT;
            end

            ST_RD_WAIT:
            begin
                out_next   = make_result(1'b1, mem_rdata, cur_fill,
                                         rd_left_reg == '0, DEPTH_C);
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = out_reg.last ? ST_IDLE : ST_RD_ISSUE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ch_reg      <= '0;
            rd_left_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                head_reg[i]    <= '0;
                tail_reg[i]    <= '0;
                fill_reg[i]    <= '0;
                wr_left_reg[i] <= '0;
                wr_rej_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            rd_left_reg <= rd_left_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fill_reg    <= fill_next;
            wr_left_reg <= wr_left_next;
            wr_rej_reg  <= wr_rej_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        out_reg <= out_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_item  = out_reg;

    // The block never takes an item while a result waits to be handed over.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while a result is pending");

    // The addressed channel never holds more than its depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[ch_reg] <= DEPTH_C)
        else $error("fill count beyond depth");

    // Once the final result of an item is taken, the block is ready again.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_item.last) |=> in_ready)
        else $error("not ready after the final result");

    // Store data is captured only right after a read was issued.
    a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_WAIT) |-> $past(mem_re))
        else $error("read data captured without a store read");

endmodule

`default_nettype wire

@@ bench/tb_dual_channel_byte_ring_fifo.sv @@
// Self-checking testbench for the dual-channel byte ring FIFO: a short
// stimulus table followed by random items, all checked against a predictor
// but typed rows. Depends on dcbrf_pkg and dual_channel_byte_ring_fifo.
`timescale 1ns / 1ps

module tb_dual_channel_byte_ring_fifo;

    import dcbrf_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int CHAN_COUNT   = CHANNELS_DEFAULT;
    localparam int RANDOM_ITEMS = 75;
    // Worst case is far below this: some 105 items, each with up to 64
    // results, each slowed by a store read and a stall on the receiving
    // side, then taken several times over.
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = 30;

    // The two mode codes that the block does not use.
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    typedef enum int {DRAIN_FREE, DRAIN_JITTER, DRAIN_CHOKED} drain_mode_t;

    // One row of the opening table. Where typed is set, the single result
    // of the row is given here; otherwise the predictor supplies it.
    typedef struct packed {
        in_item_t           item;
        logic               typed;
        logic               ok_want;
        logic [COUNT_W-1:0] used_want;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    // Travels alongside the item being offered, so that the monitor knows
    // whether a typed-in result replaces the predicted one.
    logic      cur_typed = 1'b0;
    out_item_t cur_want  = '0;

    // Predictor state: one ring per channel, plus a flag per entry that
    // records whether it has ever been written, so that the stimulus never
    // reads an entry whose content is undefined.
    logic [BYTE_W-1:0]  ring_bytes   [CHAN_COUNT][DEPTH];
    bit                 ring_written [CHAN_COUNT][DEPTH];
    logic [5:0]         head_q       [CHAN_COUNT];
    logic [5:0]         tail_q       [CHAN_COUNT];
    logic [COUNT_W-1:0] fill_q       [CHAN_COUNT];
    logic [COUNT_W-1:0] run_left_q   [CHAN_COUNT];
    bit                 run_rej_q    [CHAN_COUNT];

    out_item_t step_results [$];
    out_item_t due_results  [$];
    stim_row_t opening_rows [$];

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          burst_left     = 0;
    int          stall_left     = 0;
    int          drain_left     = 0;
    drain_mode_t drain_mode     = DRAIN_FREE;

    dual_channel_byte_ring_fifo #(
        .BUF_DEPTH (DEPTH),
        .CHANNELS  (CHAN_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // The run is ended here if the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        for (int c = 0; c < CHAN_COUNT; c++)
        begin
            head_q[c]     = '0;
            tail_q[c]     = '0;
            fill_q[c]     = '0;
            run_left_q[c] = '0;
            run_rej_q[c]  = 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                ring_bytes[c][i]   = '0;
                ring_written[c][i] = 1'b0;
            end
        end
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Writes a byte at the tail of a ring and advances the tail.
    task automatic store_byte(input int c, input logic [BYTE_W-1:0] b);
        ring_bytes[c][tail_q[c]]   = b;
        ring_written[c][tail_q[c]] = 1'b1;
        tail_q[c]                  = tail_q[c] + 6'd1;
    endtask

    // Every result shows the channel's fill count as it stands after the
    // whole item, so a run read already reports the lowered count.
    task automatic queue_status(input int c, input logic okv,
                                input logic [BYTE_W-1:0] rb, input logic fin);
        out_item_t r;
        r.ok         = okv;
        r.read_byte  = rb;
        r.used_count = fill_q[c];
        r.free_count = COUNT_W'(DEPTH) - fill_q[c];
        r.is_empty   = (fill_q[c] == '0);
        r.is_full    = (fill_q[c] >= DEPTH);
        r.last       = fin;
        step_results.push_back(r);
    endtask

    // Applies one accepted item to the rings and leaves the results that it
    // causes in step_results.
    task automatic advance_rings(input in_item_t it);
        int                c;
        int                n;
        logic              okv;
        logic [BYTE_W-1:0] rb;
        c   = int'(it.channel) % CHAN_COUNT;
        n   = int'(it.run_length);
        okv = 1'b0;
        rb  = '0;
        step_results.delete();
        case (it.mode)
            MODE_PUSH:
            begin
                if (fill_q[c] < DEPTH)
                begin
                    store_byte(c, it.data_byte);
                    fill_q[c]++;
                    okv = 1'b1;
                end
            end
            MODE_POP:
            begin
                if (fill_q[c] != 0)
                begin
                    rb        = ring_bytes[c][head_q[c]];
                    head_q[c] = head_q[c] + 6'd1;
                    fill_q[c]--;
                    okv       = 1'b1;
                end
            end
            MODE_PEEK:
            begin
                if (fill_q[c] != 0)
                begin
                    rb  = ring_bytes[c][head_q[c]];
                    okv = 1'b1;
                end
            end
            MODE_RUN_READ:
            begin
                // A short run reads nothing; an empty run succeeds at once.
                if (n > fill_q[c])
                begin
                    queue_status(c, 1'b0, '0, 1'b1);
                    return;
                end
                if (n == 0)
                begin
                    queue_status(c, 1'b1, '0, 1'b1);
                    return;
                end
                fill_q[c] = fill_q[c] - COUNT_W'(n);
                for (int i = 0; i < n; i++)
                begin
                    rb        = ring_bytes[c][head_q[c]];
                    head_q[c] = head_q[c] + 6'd1;
                    queue_status(c, 1'b1, rb, i == n - 1);
                end
                return;
            end
            MODE_RUN_WRITE:
            begin
                if (it.run_first)
                begin
                    // The whole run is reserved on its first item, or refused.
                    if (n > DEPTH - int'(fill_q[c]))
                    begin
                        run_rej_q[c]  = 1'b1;
                        run_left_q[c] = '0;
                    end
                    else
                    begin
                        run_rej_q[c]  = 1'b0;
                        fill_q[c]     = fill_q[c] + COUNT_W'(n);
                        run_left_q[c] = '0;
                        if (n != 0)
                        begin
                            store_byte(c, it.data_byte);
                            run_left_q[c] = COUNT_W'(n - 1);
                        end
                        okv = 1'b1;
                    end
                end
                else if (!run_rej_q[c] && run_left_q[c] != 0)
                begin
                    store_byte(c, it.data_byte);
                    run_left_q[c]--;
                    okv = 1'b1;
                end
            end
            MODE_STATUS:
                okv = 1'b1;
            default:
                okv = 1'b0;
        endcase
        queue_status(c, okv, rb, 1'b1);
    endtask

    // True when the next n bytes from the head have all been written at some
    // point, so that reading them is well defined.
    function automatic bit bytes_ready(input int c, input int n);
        logic [5:0] idx;
        for (int i = 0; i < n; i++)
        begin
            idx = head_q[c] + 6'(i);
            if (!ring_written[c][idx])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Builds the next random item from the rings as they stand. Pending run
    // writes are mostly carried on, so that most of the stimulus consists of
    // complete runs, with pushes, pops and noise mixed in.
    task automatic pick_random_item(output in_item_t it);
        int   roll;
        int   c;
        int   room;
        int   held;
        logic other_pending;
        it            = '0;
        c             = $urandom_range(0, CHAN_COUNT - 1);
        other_pending = run_left_q[1 - c] != 0 && !run_rej_q[1 - c];
        if (other_pending && $urandom_range(0, 9) < 7)
            c = 1 - c;
        held = int'(fill_q[c]);
        room = DEPTH - held;
        it.channel    = c[0];
        it.data_byte  = BYTE_W'($urandom_range(0, 255));
        it.run_length = COUNT_W'($urandom_range(0, 127));
        it.run_first  = 1'($urandom_range(0, 1));
        if (run_left_q[c] != 0 && !run_rej_q[c] && $urandom_range(0, 9) < 8)
        begin
            it.mode      = MODE_RUN_WRITE;
            it.run_first = 1'b0;
            return;
        end
        roll = $urandom_range(0, 99);
        if (roll < 26)
            it.mode = MODE_PUSH;
        else if (roll < 42)
            it.mode = MODE_POP;
        else if (roll < 50)
            it.mode = MODE_PEEK;
        else if (roll < 64)
        begin
            it.mode = MODE_RUN_READ;
            roll    = $urandom_range(0, 9);
            if (roll < 7)
                it.run_length = COUNT_W'((held == 0) ? 1
                                         : $urandom_range(1, (held < 8) ? held : 8));
            else if (roll == 7)
                it.run_length = '0;
            else if (roll == 8)
                it.run_length = COUNT_W'($urandom_range(held + 1, 127));
            else
                it.run_length = COUNT_W'(held);
        end
        else if (roll < 80)
        begin
            it.mode      = MODE_RUN_WRITE;
            it.run_first = 1'b1;
            roll         = $urandom_range(0, 9);
            if (roll < 7)
                it.run_length = COUNT_W'((room == 0) ? 1
                                         : $urandom_range(1, (room < 12) ? room : 12));
            else if (roll == 7)
                it.run_length = '0;
            else if (roll == 8)
                it.run_length = COUNT_W'($urandom_range(room + 1, 127));
            else
                it.run_length = COUNT_W'(room);
        end
        else if (roll < 90)
            it.mode = MODE_STATUS;
        else if (roll < 94)
        begin
            it.mode      = MODE_RUN_WRITE;
            it.run_first = 1'b0;
        end
        else
            it.mode = roll[0] ? MODE_UNUSED_HI : MODE_UNUSED_LO;

        // Reads that would reach a place reserved but never written become a
        // status query instead.
        if ((it.mode == MODE_POP || it.mode == MODE_PEEK) && held != 0 && !bytes_ready(c, 1))
            it.mode = MODE_STATUS;
        if (it.mode == MODE_RUN_READ && it.run_length <= held
            && !bytes_ready(c, int'(it.run_length)))
            it.mode = MODE_STATUS;
    endtask

    function automatic void add_row(input logic [MODE_W-1:0] md, input logic ch,
                                    input logic [BYTE_W-1:0] db,
                                    input logic [COUNT_W-1:0] len, input logic first,
                                    input logic typed, input logic ok_want,
                                    input logic [COUNT_W-1:0] used_want);
        stim_row_t row;
        row.item.mode       = md;
        row.item.channel    = ch;
        row.item.data_byte  = db;
        row.item.run_length = len;
        row.item.run_first  = first;
        row.typed           = typed;
        row.ok_want         = ok_want;
        row.used_want       = used_want;
        opening_rows.push_back(row);
    endfunction

    // The sender works in bursts; between bursts it drops valid for a random
    // pause. Some bursts are long enough to keep the block busy throughout.
    task automatic pace_sender();
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
    endtask

    // Offers one item at a falling edge and holds it until the block takes
    // it, then returns at the next falling edge.
    task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
        in_item   <= it;
        cur_typed <= typed;
        cur_want  <= want;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // The receiver switches between taking every result, short random
    // stalls and long stalls, each for a stretch of cycles.
    always @(negedge clk)
    begin
        if (drain_left == 0)
        begin
            drain_mode = drain_mode_t'($urandom_range(0, 2));
            drain_left = $urandom_range(16, 80);
        end
        drain_left--;
        if (stall_left != 0)
            stall_left--;
        else if (drain_mode == DRAIN_JITTER && $urandom_range(0, 1) == 1)
            stall_left = $urandom_range(1, 3);
        else if (drain_mode == DRAIN_CHOKED && $urandom_range(0, 3) != 0)
            stall_left = $urandom_range(2, 7);
        out_ready <= (stall_left == 0) && rst_n;
    end

    // Monitor: both handshakes are sampled at the same rising edge. An
    // accepted item is applied to the predictor first; an accepted result is
    // then compared with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                advance_rings(in_item);
                if (cur_typed)
                    due_results.push_back(cur_want);
                else
                    foreach (step_results[i])
                        due_results.push_back(step_results[i]);
            end
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                    flag_mismatch("result with nothing outstanding", 1, 0);
                else
                begin
                    want = due_results.pop_front();
                    if (out_item.ok !== want.ok)
                        flag_mismatch("ok", out_item.ok, want.ok);
                    if (out_item.read_byte !== want.read_byte)
                        flag_mismatch("read_byte", out_item.read_byte, want.read_byte);
                    if (out_item.used_count !== want.used_count)
                        flag_mismatch("used_count", out_item.used_count, want.used_count);
                    if (out_item.free_count !== want.free_count)
                        flag_mismatch("free_count", out_item.free_count, want.free_count);
                    if (out_item.is_empty !== want.is_empty)
                        flag_mismatch("is_empty", out_item.is_empty, want.is_empty);
                    if (out_item.is_full !== want.is_full)
                        flag_mismatch("is_full", out_item.is_full, want.is_full);
                    if (out_item.last !== want.last)
                        flag_mismatch("last", out_item.last, want.last);
                end
            end
        end
    end

    initial
    begin
        in_item_t  it;
        out_item_t want;
        int        counted;

        // Opening table. Rows with a typed result have an answer plain from
        // the rules: status, pushes, empty and full refusals, short and empty
        // runs, refused runs, a reservation that fills the ring, unused modes.
        add_row(MODE_STATUS,    1'b0, 8'h00, 7'd0,   1'b0, 1'b1, 1'b1, 7'd0);
        add_row(MODE_POP,       1'b0, 8'h00, 7'd0,   1'b0, 1'b1, 1'b0, 7'd0);
        add_row(MODE_PEEK,      1'b1, 8'hFF, 7'd127, 1'b1, 1'b1, 1'b0, 7'd0);
        add_row(MODE_RUN_READ,  1'b0, 8'h00, 7'd0,   1'b0, 1'b1, 1'b1, 7'd0);
        add_row(MODE_RUN_READ,  1'b1, 8'h00, 7'd1,   1'b0, 1'b1, 1'b0, 7'd0);
        add_row(MODE_RUN_READ,  1'b0, 8'h00, 7'd127, 1'b0, 1'b1, 1'b0, 7'd0);
        // A run write byte with no run pending is refused.
        add_row(MODE_RUN_WRITE, 1'b0, 8'h55, 7'd5,   1'b0, 1'b1, 1'b0, 7'd0);
        add_row(MODE_UNUSED_LO, 1'b1, 8'h00, 7'd0,   1'b0, 1'b1, 1'b0, 7'd0);
        add_row(MODE_UNUSED_HI, 1'b0, 8'hFF, 7'd127, 1'b1, 1'b1, 1'b0, 7'd0);
        add_row(MODE_PUSH,      1'b0, 8'h00, 7'd0,   1'b0, 1'b1, 1'b1, 7'd1);
        add_row(MODE_PUSH,      1'b0, 8'hFF, 7'd127, 1'b1, 1'b1, 1'b1, 7'd2);
        add_row(MODE_PEEK,      1'b0, 8'h00, 7'd0,   1'b0, 1'b0, 1'b0, 7'd0);
        add_row(MODE_POP,       1'b0, 8'h00, 7'd0,   1'b0, 1'b0, 1'b0, 7'd0);
        // A run longer than the free space is refused, and so is every
        // later byte of it.
        add_row(MODE_RUN_WRITE, 1'b1, 8'h11, 7'd127, 1'b1, 1'b1, 1'b0, 7'd0);
        add_row(MODE_RUN_WRITE, 1'b1, 8'h81, 7'd0,   1'b0, 1'b1, 1'b0, 7'd0);
        add_row(MODE_RUN_WRITE, 1'b1, 8'h22, 7'd0,   1'b1, 1'b1, 1'b1, 7'd0);
        // A run of three with a push slipped in between its bytes, then one
        // byte too many, then a run read of all four.
        add_row(MODE_RUN_WRITE, 1'b1, 8'hA5, 7'd3,   1'b1, 1'b0, 1'b0, 7'd0);
        add_row(MODE_PUSH,      1'b1, 8'h5A, 7'd0,   1'b0, 1'b0, 1'b0, 7'd0);
        add_row(MODE_RUN_WRITE, 1'b1, 8'h3C, 7'd64,  1'b0, 1'b0, 1'b0, 7'd0);
        add_row(MODE_RUN_WRITE, 1'b1, 8'hC3, 7'd0,   1'b0, 1'b0, 1'b0, 7'd0);
        add_row(MODE_RUN_WRITE, 1'b1, 8'h99, 7'd0,   1'b0, 1'b0, 1'b0, 7'd0);
        add_row(MODE_RUN_READ,  1'b1, 8'h00, 7'd4,   1'b0, 1'b0, 1'b0, 7'd0);
        add_row(MODE_STATUS,    1'b1, 8'h00, 7'd0,   1'b0, 1'b1, 1'b1, 7'd0);
        // Reserving every free place fills the ring at once; the remaining
        // bytes of this run are carried on by the random part.
        add_row(MODE_RUN_WRITE, 1'b0, 8'h7E, 7'd63,  1'b1, 1'b1, 1'b1, 7'd64);
        add_row(MODE_PUSH,      1'b0, 8'h01, 7'd0,   1'b0, 1'b1, 1'b0, 7'd64);

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening_rows[i])
        begin
            want            = '0;
            want.ok         = opening_rows[i].ok_want;
            want.used_count = opening_rows[i].used_want;
            want.free_count = COUNT_W'(DEPTH) - opening_rows[i].used_want;
            want.is_empty   = (opening_rows[i].used_want == '0);
            want.is_full    = (opening_rows[i].used_want >= DEPTH);
            want.last       = 1'b1;
            pace_sender();
            send_item(opening_rows[i].item, opening_rows[i].typed, want);
        end

        // Random part. Items in the unused modes are sent but not counted.
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            pick_random_item(it);
            if (it.mode <= MODE_STATUS)
                counted++;
            pace_sender();
            send_item(it, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
design/dcbrf_pkg.sv
design/dcbrf_store.sv
design/dual_channel_byte_ring_fifo.sv
bench/tb_dual_channel_byte_ring_fifo.sv
